/* src/lslf_pkg.sv */
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared widths, codes and controller/datapath types of the line fit block.
// ----------------------------------------------------------------------------
package lslf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MAX_POINTS = 1024;
	localparam int POS_W      = $clog2(MAX_POINTS + 1);
	localparam int START_W    = 10;
	localparam int END_W      = 11;
	localparam int SX_W       = 27;
	localparam int SXY_W      = 42;
	localparam int SXX_W      = 41;
	localparam int LO_W       = 21;
	localparam int NUM_W      = 54;
	localparam int MA_W       = 32;
	localparam int MB_W       = 28;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int DVD_W      = 70;
	localparam int DVS_W      = 54;
	localparam int Q_W        = 34;
	localparam int STEP_W     = $clog2(DVD_W + 1);
	localparam int FRAC_SHIFT = 17;
	localparam int OUT_W      = 32;
	localparam int ST_W       = 2;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_NONE = 2'd1;
	localparam logic [ST_W-1:0] ST_VERT = 2'd2;
	localparam logic [ST_W-1:0] ST_SAT  = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_NUM_LO,
		OP_NUM_HI,
		OP_NUM_SS,
		OP_DEN_LO,
		OP_DEN_HI,
		OP_DEN_SS,
		OP_DEN_END,
		OP_SDIV_LOAD,
		OP_SLOPE,
		OP_ICPT_MUL,
		OP_IDIV_LOAD,
		OP_ICPT,
		OP_FIT0_MUL,
		OP_FIT1_MUL,
		OP_FIT_END
	} dp_op_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_NONE,
		RES_VERT
	} res_kind_t;

	typedef struct packed {
		logic      acc_en;
		logic      load;
		dp_op_t    op;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic den_bad;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

endpackage

/* src/lslf_ifs.sv */
// ----------------------------------------------------------------------------
// lslf channel interfaces
// Sample request channel and fit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lslf_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [lslf_pkg::SAMPLE_W-1:0]  x_sample;
	logic signed [lslf_pkg::SAMPLE_W-1:0]  y_sample;
	logic                                  last_point;

	modport source (output valid, x_sample, y_sample, last_point, input ready);
	modport sink (input valid, x_sample, y_sample, last_point, output ready);
endinterface

interface lslf_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [lslf_pkg::OUT_W-1:0]     slope;
	logic signed [lslf_pkg::OUT_W-1:0]     intercept;
	logic signed [lslf_pkg::SAMPLE_W-1:0]  first_x;
	logic signed [lslf_pkg::OUT_W-1:0]     first_y_fit;
	logic signed [lslf_pkg::SAMPLE_W-1:0]  last_x;
	logic signed [lslf_pkg::OUT_W-1:0]     last_y_fit;
	logic [lslf_pkg::ST_W-1:0]             fit_status;

	modport source (output valid, slope, intercept, first_x, first_y_fit, last_x,
		last_y_fit, fit_status, input ready);
	modport sink (input valid, slope, intercept, first_x, first_y_fit, last_x,
		last_y_fit, fit_status, output ready);
endinterface

/* src/lslf_div.sv */
// ----------------------------------------------------------------------------
// lslf_div
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
module lslf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lslf_pkg::DVD_W-1:0] dividend,
	input  logic [lslf_pkg::DVS_W-1:0] divisor,
	output logic                       busy,
	output logic [lslf_pkg::Q_W-1:0]   quot,
	output logic                       over
);
	import lslf_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [Q_W-1:0]    quo_q;
	logic              over_q;
	logic [DVS_W:0]    trial_w;
	logic              ge_w;

	assign trial_w = {rem_q, dvd_q[DVD_W-1]};
	assign ge_w    = trial_w >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			over_q <= 1'b0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge_w ? DVS_W'(trial_w - {1'b0, dvs_q}) : DVS_W'(trial_w);
			quo_q  <= {quo_q[Q_W-2:0], ge_w};
			over_q <= over_q | quo_q[Q_W-1];
			dvd_q  <= dvd_q << 1;
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;
	assign over = over_q;

endmodule

/* src/lslf_ctrl.sv */
// ----------------------------------------------------------------------------
// lslf_ctrl
// Sequencer: accumulate phase, then the fit sequence on the last point.
// ----------------------------------------------------------------------------
module lslf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  lslf_pkg::dp_stat_t  stat,
	output lslf_pkg::dp_cmd_t   cmd
);
	import lslf_pkg::*;

	typedef enum logic [4:0] {
		S_ACC, S_START, S_NUM_HI, S_NUM_SS, S_DEN_LO, S_DEN_HI, S_DEN_SS,
		S_DEN_END, S_CHECK, S_SDIV, S_SLOPE, S_ICPT_MUL, S_IDIV_LOAD, S_IDIV,
		S_ICPT, S_FIT0, S_FIT1, S_FIT_END, S_FIN
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			kind_q  <= RES_OK;
		end else begin
			case (state_q)
				S_ACC:       if (in_valid && in_last) state_q <= S_START;
				S_START: begin
					if (stat.n_zero) begin
						kind_q  <= RES_NONE;
						state_q <= S_FIN;
					end else begin
						state_q <= S_NUM_HI;
					end
				end
				S_NUM_HI:    state_q <= S_NUM_SS;
				S_NUM_SS:    state_q <= S_DEN_LO;
				S_DEN_LO:    state_q <= S_DEN_HI;
				S_DEN_HI:    state_q <= S_DEN_SS;
				S_DEN_SS:    state_q <= S_DEN_END;
				S_DEN_END:   state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.den_bad) begin
						kind_q  <= RES_VERT;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SDIV;
					end
				end
				S_SDIV:      if (!stat.div_busy) state_q <= S_SLOPE;
				S_SLOPE:     state_q <= S_ICPT_MUL;
				S_ICPT_MUL:  state_q <= S_IDIV_LOAD;
				S_IDIV_LOAD: state_q <= S_IDIV;
				S_IDIV:      if (!stat.div_busy) state_q <= S_ICPT;
				S_ICPT:      state_q <= S_FIT0;
				S_FIT0:      state_q <= S_FIT1;
				S_FIT1:      state_q <= S_FIT_END;
				S_FIT_END: begin
					kind_q  <= RES_OK;
					state_q <= S_FIN;
				end
				S_FIN:       if (stat.out_free) state_q <= S_ACC;
				default:     state_q <= S_ACC;
			endcase
		end
	end

	always_comb begin
		cmd.acc_en = (state_q == S_ACC) && in_valid;
		cmd.load   = (state_q == S_FIN) && stat.out_free;
		cmd.kind   = kind_q;
		case (state_q)
			S_START:     cmd.op = OP_NUM_LO;
			S_NUM_HI:    cmd.op = OP_NUM_HI;
			S_NUM_SS:    cmd.op = OP_NUM_SS;
			S_DEN_LO:    cmd.op = OP_DEN_LO;
			S_DEN_HI:    cmd.op = OP_DEN_HI;
			S_DEN_SS:    cmd.op = OP_DEN_SS;
			S_DEN_END:   cmd.op = OP_DEN_END;
			S_CHECK:     cmd.op = stat.den_bad ? OP_NOP : OP_SDIV_LOAD;
			S_SLOPE:     cmd.op = OP_SLOPE;
			S_ICPT_MUL:  cmd.op = OP_ICPT_MUL;
			S_IDIV_LOAD: cmd.op = OP_IDIV_LOAD;
			S_ICPT:      cmd.op = OP_ICPT;
			S_FIT0:      cmd.op = OP_FIT0_MUL;
			S_FIT1:      cmd.op = OP_FIT1_MUL;
			S_FIT_END:   cmd.op = OP_FIT_END;
			default:     cmd.op = OP_NOP;
		endcase
	end

	assign in_ready = state_q == S_ACC;

endmodule

/* src/lslf_dp.sv */
// ----------------------------------------------------------------------------
// lslf_dp
// Accumulators, shared multiplier, divider and result register.
// ----------------------------------------------------------------------------
module lslf_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lslf_pkg::dp_cmd_t                    cmd,
	output lslf_pkg::dp_stat_t                   stat,
	input  logic signed [lslf_pkg::SAMPLE_W-1:0] x_sample,
	input  logic signed [lslf_pkg::SAMPLE_W-1:0] y_sample,
	input  logic [lslf_pkg::START_W-1:0]         window_start,
	input  logic [lslf_pkg::END_W-1:0]           window_end,
	lslf_out_if.source                           out_ch
);
	import lslf_pkg::*;

	localparam logic signed [PROD_W-1:0] HI_LIM = PROD_W'(64'd2147483647);
	localparam logic signed [PROD_W-1:0] LO_LIM = -(PROD_W'(64'd2147483648));
	localparam logic [Q_W-2:0] POS_LIM = (Q_W-1)'(64'h7FFF_FFFF);
	localparam logic [Q_W-2:0] NEG_LIM = (Q_W-1)'(64'h8000_0000);
	localparam logic [Q_W-1:0] IPOS_LIM = Q_W'(64'h7FFF_FFFF);
	localparam logic [Q_W-1:0] INEG_LIM = Q_W'(64'h8000_0000);
	localparam logic signed [OUT_W-1:0] S_MAX = OUT_W'(64'h7FFF_FFFF);
	localparam logic signed [OUT_W-1:0] S_MIN = OUT_W'(64'h8000_0000);

	function automatic logic [OUT_W:0] sat32(input logic signed [PROD_W-1:0] v);
		logic [OUT_W:0] r;
		if (v > HI_LIM) r = {1'b1, S_MAX};
		else if (v < LO_LIM) r = {1'b1, S_MIN};
		else r = {1'b0, v[OUT_W-1:0]};
		return r;
	endfunction

	logic [POS_W-1:0]           n_q, pos_q;
	logic signed [SX_W-1:0]     sum_x_q, sum_y_q;
	logic signed [SXY_W-1:0]    sum_xy_q;
	logic [SXX_W-1:0]           sum_xx_q;
	logic signed [SAMPLE_W-1:0] fx0_q, fx1_q;
	logic signed [2*SAMPLE_W-1:0] xy_w;
	logic [2*SAMPLE_W-1:0]      xx_w;
	logic                       keep_w;

	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]   prod_w, prod_q;
	logic signed [NUM_W-1:0]    acc_q, num_q, den_q;
	logic [NUM_W-1:0]           num_mag_w;
	logic signed [PROD_W-1:0]   a_w;
	logic [PROD_W-1:0]          a_mag_w;
	logic                       a_neg_q;

	logic                       div_start;
	logic [DVD_W-1:0]           div_dvd;
	logic [DVS_W-1:0]           div_dvs;
	logic                       div_busy;
	logic [Q_W-1:0]             quot;
	logic                       div_over;

	logic [Q_W-1:0]             rnd_w;
	logic [Q_W-2:0]             m_w;
	logic signed [OUT_W-1:0]    slope_w, icpt_w;
	logic                       slope_sat_w, icpt_sat_w;
	logic [OUT_W:0]             fit_w;
	logic signed [OUT_W-1:0]    slope_q, icpt_q, fy0_q, fy1_q;
	logic                       sat_q;

	logic                       out_valid_q;
	logic signed [OUT_W-1:0]    o_slope_q, o_icpt_q, o_fy0_q, o_fy1_q;
	logic signed [SAMPLE_W-1:0] o_fx0_q, o_fx1_q;
	logic [ST_W-1:0]            o_st_q;

	// sample accumulation
	assign xy_w   = x_sample * y_sample;
	assign xx_w   = x_sample * x_sample;
	assign keep_w = (pos_q < POS_W'(MAX_POINTS)) && (pos_q >= POS_W'(window_start))
		&& (pos_q < window_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			pos_q    <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
			fx0_q    <= '0;
			fx1_q    <= '0;
		end else if (cmd.load) begin
			n_q      <= '0;
			pos_q    <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
			fx0_q    <= '0;
			fx1_q    <= '0;
		end else if (cmd.acc_en) begin
			if (keep_w) begin
				if (n_q == '0) fx0_q <= x_sample;
				fx1_q    <= x_sample;
				n_q      <= n_q + 1'b1;
				sum_x_q  <= sum_x_q + SX_W'(x_sample);
				sum_y_q  <= sum_y_q + SX_W'(y_sample);
				sum_xy_q <= sum_xy_q + SXY_W'(xy_w);
				sum_xx_q <= sum_xx_q + SXX_W'(xx_w);
			end
			if (pos_q < POS_W'(MAX_POINTS)) pos_q <= pos_q + 1'b1;
		end
	end

	// shared multiplier
	always_comb begin
		case (cmd.op)
			OP_NUM_LO: begin
				mul_a = MA_W'(n_q);
				mul_b = MB_W'(sum_xy_q[LO_W-1:0]);
			end
			OP_NUM_HI: begin
				mul_a = MA_W'(n_q);
				mul_b = MB_W'($signed(sum_xy_q[SXY_W-1:LO_W]));
			end
			OP_NUM_SS: begin
				mul_a = MA_W'(sum_x_q);
				mul_b = MB_W'(sum_y_q);
			end
			OP_DEN_LO: begin
				mul_a = MA_W'(n_q);
				mul_b = MB_W'(sum_xx_q[LO_W-1:0]);
			end
			OP_DEN_HI: begin
				mul_a = MA_W'(n_q);
				mul_b = MB_W'(sum_xx_q[SXX_W-1:LO_W]);
			end
			OP_DEN_SS: begin
				mul_a = MA_W'(sum_x_q);
				mul_b = MB_W'(sum_x_q);
			end
			OP_ICPT_MUL: begin
				mul_a = slope_q;
				mul_b = MB_W'(sum_x_q);
			end
			OP_FIT0_MUL: begin
				mul_a = slope_q;
				mul_b = MB_W'(fx0_q);
			end
			OP_FIT1_MUL: begin
				mul_a = slope_q;
				mul_b = MB_W'(fx1_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_w = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod_w;
	end

	// divider operands
	assign num_mag_w = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign a_w       = (PROD_W'(sum_y_q) <<< 16) - prod_q;
	assign a_mag_w   = a_w[PROD_W-1] ? PROD_W'(-a_w) : PROD_W'(a_w);
	assign div_start = (cmd.op == OP_SDIV_LOAD) || (cmd.op == OP_IDIV_LOAD);
	assign div_dvd   = (cmd.op == OP_SDIV_LOAD) ? (DVD_W'(num_mag_w) << FRAC_SHIFT)
		: (DVD_W'(a_mag_w) + DVD_W'(n_q >> 1));
	assign div_dvs   = (cmd.op == OP_SDIV_LOAD) ? DVS_W'(den_q) : DVS_W'(n_q);

	lslf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (quot),
		.over     (div_over)
	);

	// slope rounding, slope and intercept saturation
	assign rnd_w = {1'b0, quot[Q_W-2:0]} + Q_W'(1);
	assign m_w   = rnd_w[Q_W-1:1];

	always_comb begin
		slope_sat_w = 1'b0;
		if (div_over || quot[Q_W-1]) begin
			slope_sat_w = 1'b1;
			slope_w     = num_q[NUM_W-1] ? S_MIN : S_MAX;
		end else if (num_q[NUM_W-1]) begin
			if (m_w > NEG_LIM) begin
				slope_sat_w = 1'b1;
				slope_w     = S_MIN;
			end else begin
				slope_w = OUT_W'(~m_w + 1'b1);
			end
		end else begin
			if (m_w > POS_LIM) begin
				slope_sat_w = 1'b1;
				slope_w     = S_MAX;
			end else begin
				slope_w = OUT_W'(m_w);
			end
		end
	end

	always_comb begin
		icpt_sat_w = 1'b0;
		if (a_neg_q) begin
			if (div_over || quot > INEG_LIM) begin
				icpt_sat_w = 1'b1;
				icpt_w     = S_MIN;
			end else begin
				icpt_w = OUT_W'(~quot + 1'b1);
			end
		end else begin
			if (div_over || quot > IPOS_LIM) begin
				icpt_sat_w = 1'b1;
				icpt_w     = S_MAX;
			end else begin
				icpt_w = OUT_W'(quot);
			end
		end
	end

	assign fit_w = sat32(prod_q + PROD_W'(icpt_q));

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_NUM_HI:    acc_q <= NUM_W'(prod_q);
			OP_NUM_SS:    acc_q <= acc_q + (NUM_W'(prod_q) <<< LO_W);
			OP_DEN_LO:    num_q <= acc_q - NUM_W'(prod_q);
			OP_DEN_HI:    acc_q <= NUM_W'(prod_q);
			OP_DEN_SS:    acc_q <= acc_q + (NUM_W'(prod_q) <<< LO_W);
			OP_DEN_END:   den_q <= acc_q - NUM_W'(prod_q);
			OP_SLOPE: begin
				slope_q <= slope_w;
				sat_q   <= slope_sat_w;
			end
			OP_IDIV_LOAD: a_neg_q <= a_w[PROD_W-1];
			OP_ICPT: begin
				icpt_q <= icpt_w;
				sat_q  <= sat_q | icpt_sat_w;
			end
			OP_FIT1_MUL: begin
				fy0_q <= fit_w[OUT_W-1:0];
				sat_q <= sat_q | fit_w[OUT_W];
			end
			OP_FIT_END: begin
				fy1_q <= fit_w[OUT_W-1:0];
				sat_q <= sat_q | fit_w[OUT_W];
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.kind)
				RES_NONE: begin
					o_slope_q <= '0;
					o_icpt_q  <= '0;
					o_fx0_q   <= '0;
					o_fy0_q   <= '0;
					o_fx1_q   <= '0;
					o_fy1_q   <= '0;
					o_st_q    <= ST_NONE;
				end
				RES_VERT: begin
					o_slope_q <= '0;
					o_icpt_q  <= '0;
					o_fx0_q   <= fx0_q;
					o_fy0_q   <= '0;
					o_fx1_q   <= fx1_q;
					o_fy1_q   <= '0;
					o_st_q    <= ST_VERT;
				end
				default: begin
					o_slope_q <= slope_q;
					o_icpt_q  <= icpt_q;
					o_fx0_q   <= fx0_q;
					o_fy0_q   <= fy0_q;
					o_fx1_q   <= fx1_q;
					o_fy1_q   <= fy1_q;
					o_st_q    <= sat_q ? ST_SAT : ST_OK;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.slope       = o_slope_q;
	assign out_ch.intercept   = o_icpt_q;
	assign out_ch.first_x     = o_fx0_q;
	assign out_ch.first_y_fit = o_fy0_q;
	assign out_ch.last_x      = o_fx1_q;
	assign out_ch.last_y_fit  = o_fy1_q;
	assign out_ch.fit_status  = o_st_q;

	assign stat.n_zero   = n_q == '0;
	assign stat.den_bad  = den_q[NUM_W-1] || (den_q == '0);
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || out_ch.ready;

	a_count_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= pos_q)
		else $error("kept count exceeds position");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q && n_q == '0 && pos_q == '0)
		else $error("result load did not present result or clear sums");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && o_st_q == ST_NONE |-> o_slope_q == '0 && o_fx1_q == '0)
		else $error("empty set result carries data");

endmodule

/* src/least_squares_line_fit_top.sv */
// ----------------------------------------------------------------------------
// least_squares_line_fit_top
// Windowed least-squares line fit over a stream of (x, y) sample requests.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    x_sample, y_sample, last_point
//   out_ch    out  valid/ready    slope, intercept, first_x, first_y_fit,
//                                 last_x, last_y_fit, fit_status
//   apb       in   psel/penable   window_start @0x0, window_end @0x4
//
// Samples are taken one per cycle while accumulating.
// A last_point request starts the fit, which includes two
// 70-step runs of the bit-serial divider (slope, then intercept).
// Requests are held off during the fit and while a finished result
// cannot enter the result register; the result register waits on out_ch.ready.
// Reset clears the sums, the position and the window to [0, 1024).
// ----------------------------------------------------------------------------
module least_squares_line_fit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	lslf_in_if.sink     in_ch,
	lslf_out_if.source  out_ch
);
	import lslf_pkg::*;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	logic [START_W-1:0] start_q;
	logic [END_W-1:0]   end_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= END_W'(MAX_POINTS);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_START: start_q <= pwdata[START_W-1:0];
				REG_END:   end_q   <= pwdata[END_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_END) ? 32'(end_q) : 32'(start_q);
	assign pready = 1'b1;

	lslf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last_point),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lslf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.x_sample     (in_ch.x_sample),
		.y_sample     (in_ch.y_sample),
		.window_start (start_q),
		.window_end   (end_q),
		.out_ch       (out_ch)
	);

endmodule
